FILE: sv/rgbe_pkg.sv
// ----------------------------------------------------------------------------
// rgbe_pkg
// Shared types and constants of the RDS group biphase encoder.
// ----------------------------------------------------------------------------
package rgbe_pkg;

    localparam int WORD_W  = 26;
    localparam int DATA_W  = 16;
    localparam int CHECK_W = 10;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [CHECK_W-1:0] t_check;

    // request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // offset words
    localparam t_check OFS_A  = 10'h0FC;
    localparam t_check OFS_B  = 10'h198;
    localparam t_check OFS_C  = 10'h168;
    localparam t_check OFS_CP = 10'h350;
    localparam t_check OFS_D  = 10'h1B4;

    // x^(i+10) mod g(x), g = 0x5B9, for data bit i
    localparam t_check SYNDROME [DATA_W] = '{
        10'h1B9, 10'h372, 10'h35D, 10'h303, 10'h3BF, 10'h2C7, 10'h037, 10'h06E,
        10'h0DC, 10'h1B8, 10'h370, 10'h359, 10'h30B, 10'h3AF, 10'h2E7, 10'h077
    };

    localparam logic [4:0] LAST_BIT = 5'd25;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic        half;
        t_word [3:0] words;
    } t_cmd;

    function automatic t_word make_word(input logic [DATA_W-1:0] data, input t_check ofs);
        t_check chk;
        chk = ofs;
        for (int i = 0; i < DATA_W; i++) begin
            if (data[i]) begin
                chk = chk ^ SYNDROME[i];
            end
        end
        return {data, chk};
    endfunction

endpackage

FILE: sv/rgbe_front.sv
// ----------------------------------------------------------------------------
// rgbe_front
// Accepts request words, drops unused codes and builds the four coded
// block words of an add request.
// ----------------------------------------------------------------------------
module rgbe_front import rgbe_pkg::*; (
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_block_a,
    input  logic [15:0] i_block_b,
    input  logic [15:0] i_block_c,
    input  logic [15:0] i_block_d,
    input  logic        i_use_c_prime,
    input  logic        i_half,
    input  logic        i_q_full,
    input  logic        i_init_busy,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic take;
    logic known;

    assign o_stall = i_q_full || i_init_busy;
    assign take    = i_valid && !o_stall;

    always_comb begin
        known      = 1'b1;
        o_cmd.kind = CMD_ADD;
        case (i_req_type)
            REQ_ADD: begin
                o_cmd.kind = CMD_ADD;
            end
            REQ_TICK: begin
                o_cmd.kind = CMD_TICK;
            end
            REQ_CLEAR: begin
                o_cmd.kind = CMD_CLEAR;
            end
            default: begin
                known = 1'b0;
            end
        endcase
        o_cmd.half     = i_half;
        o_cmd.words[0] = make_word(i_block_a, OFS_A);
        o_cmd.words[1] = make_word(i_block_b, OFS_B);
        o_cmd.words[2] = make_word(i_block_c, i_use_c_prime ? OFS_CP : OFS_C);
        o_cmd.words[3] = make_word(i_block_d, OFS_D);
    end

    assign o_push = take && known;

endmodule

FILE: sv/rgbe_queue.sv
// ----------------------------------------------------------------------------
// rgbe_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module rgbe_queue import rgbe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_cmd o_head
);

    localparam logic [1:0] QDEPTH = 2'd2;

    t_cmd       r_mem [2];
    logic [0:0] r_wptr;
    logic [0:0] r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full       = (r_count == QDEPTH);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

FILE: sv/rgbe_back.sv
// ----------------------------------------------------------------------------
// rgbe_back
// Executes queued commands: ring writes, ring clearing sweep and half-bit
// ticks with differential biphase coding; holds the output register.
// ----------------------------------------------------------------------------
module rgbe_back import rgbe_pkg::*; #(
    parameter int RING_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_head_valid,
    input  t_cmd i_head,
    output logic o_pop,
    output logic o_init_busy,
    output logic o_valid,
    input  logic i_stall,
    output logic o_waveform_select,
    output logic o_polarity,
    output logic o_half_out
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_LOAD  = 3'b010,
        ST_CLEAR = 3'b100
    } t_bstate;

    t_bstate       r_state, n_state;
    logic          r_init, n_init;
    logic [AW-1:0] r_sweep, n_sweep;
    logic [1:0]    r_sub, n_sub;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [4:0]    r_bit_cnt, n_bit_cnt;
    t_word         r_bit_shift, n_bit_shift;
    logic          r_last, n_last;
    logic [31:0]   r_coded, n_coded;
    logic          r_o_valid;
    logic          r_wsel;
    logic          r_pol;
    logic          r_hout;

    t_word         r_ring [RING_DEPTH];
    t_word         r_rdata;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_word         wr_data;
    logic          out_free;
    logic          tick_go;
    logic          lvl;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    assign out_free = !r_o_valid || !i_stall;
    assign tick_go  = (r_state == ST_RUN) && i_head_valid &&
                      (i_head.kind == CMD_TICK) && out_free;

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_sweep     = r_sweep;
        n_sub       = r_sub;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_bit_cnt   = r_bit_cnt;
        n_bit_shift = r_bit_shift;
        n_last      = r_last;
        n_coded     = r_coded;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_wr_idx;
        wr_data     = '0;
        lvl         = r_last ^ r_bit_shift[WORD_W-1];
        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_sweep;
                if (r_sweep == LAST_IDX) begin
                    n_state = ST_RUN;
                    n_init  = 1'b0;
                    n_sweep = '0;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            ST_LOAD: begin
                n_bit_shift = r_rdata;
                n_state     = ST_RUN;
            end
            ST_RUN: begin
                if (i_head_valid) begin
                    case (i_head.kind)
                        CMD_ADD: begin
                            wr_en    = 1'b1;
                            wr_data  = i_head.words[r_sub];
                            n_wr_idx = ring_inc(r_wr_idx);
                            n_sub    = r_sub + 2'd1;
                            o_pop    = (r_sub == 2'd3);
                        end
                        CMD_CLEAR: begin
                            o_pop   = 1'b1;
                            n_state = ST_CLEAR;
                            n_sweep = '0;
                        end
                        CMD_TICK: begin
                            if (out_free) begin
                                o_pop   = 1'b1;
                                n_coded = {r_coded[30:0], 1'b0};
                                if (i_head.half) begin
                                    n_last        = lvl;
                                    n_coded[1:0]  = n_coded[1:0] | (lvl ? 2'b10 : 2'b01);
                                    n_bit_shift   = {r_bit_shift[WORD_W-2:0], 1'b0};
                                    if (r_bit_cnt == LAST_BIT) begin
                                        n_bit_cnt = '0;
                                        n_rd_idx  = ring_inc(r_rd_idx);
                                        n_state   = ST_LOAD;
                                    end else begin
                                        n_bit_cnt = r_bit_cnt + 5'd1;
                                    end
                                end
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_init      <= 1'b1;
            r_sweep     <= '0;
            r_sub       <= '0;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_bit_cnt   <= '0;
            r_bit_shift <= '0;
            r_last      <= 1'b0;
            r_coded     <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_sweep     <= n_sweep;
            r_sub       <= n_sub;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_bit_cnt   <= n_bit_cnt;
            r_bit_shift <= n_bit_shift;
            r_last      <= n_last;
            r_coded     <= n_coded;
            if (tick_go) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_wsel <= r_coded[31] ^ r_coded[30];
            r_pol  <= r_coded[30];
            r_hout <= i_head.half;
        end
    end

    // ring: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_addr] <= wr_data;
        end
        r_rdata <= r_ring[r_rd_idx];
    end

    assign o_init_busy       = r_init;
    assign o_valid           = r_o_valid;
    assign o_waveform_select = r_wsel;
    assign o_polarity        = r_pol;
    assign o_half_out        = r_hout;

`ifndef NO_ASSERTIONS
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD |=> r_state == ST_RUN)
        else $error("ring load stage held longer than one cycle");

    a_no_write_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD |-> !wr_en)
        else $error("ring written while a reload is pending");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && r_sweep == LAST_IDX) |=> r_state == ST_RUN && !r_init)
        else $error("clearing sweep did not finish");

    a_out_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(tick_go))
        else $error("output word without a tick");

    a_bit_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= LAST_BIT)
        else $error("bit counter out of range");
`endif

endmodule

FILE: sv/rds_group_biphase_encoder.sv
// ----------------------------------------------------------------------------
// rds_group_biphase_encoder
// RDS group encoder with differential biphase output.
// ----------------------------------------------------------------------------
// A half-bit tick word gives one output word; the tick that finishes a 26-bit
// block also passes the back end through its load state, as the next ring word
// comes through the ring's registered read port. An add-group word makes four
// ring writes, one per coded block word. A clear word sweeps the ring at one
// entry per cycle; the same sweep runs after reset with o_stall held high. A
// two-entry queue lets input words be taken while the back end works or the
// output word waits.
// ----------------------------------------------------------------------------
module rds_group_biphase_encoder import rgbe_pkg::*; #(
    parameter int RING_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_block_a,
    input  logic [15:0] i_block_b,
    input  logic [15:0] i_block_c,
    input  logic [15:0] i_block_d,
    input  logic        i_use_c_prime,
    input  logic        i_half,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_waveform_select,
    output logic        o_polarity,
    output logic        o_half_out
);

    logic push;
    t_cmd cmd;
    logic q_full;
    logic pop;
    logic head_valid;
    t_cmd head;
    logic init_busy;

    rgbe_front u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_block_a     (i_block_a),
        .i_block_b     (i_block_b),
        .i_block_c     (i_block_c),
        .i_block_d     (i_block_d),
        .i_use_c_prime (i_use_c_prime),
        .i_half        (i_half),
        .i_q_full      (q_full),
        .i_init_busy   (init_busy),
        .o_push        (push),
        .o_cmd         (cmd)
    );

    rgbe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    rgbe_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head_valid      (head_valid),
        .i_head            (head),
        .o_pop             (pop),
        .o_init_busy       (init_busy),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_waveform_select (o_waveform_select),
        .o_polarity        (o_polarity),
        .o_half_out        (o_half_out)
    );

endmodule

FILE: sim/rds_group_biphase_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rds_group_biphase_encoder_tb
// Self-checking bench for the RDS group encoder with biphase output.
// ----------------------------------------------------------------------------
// Group, tick, clear and unused-code words go in through a valid/stall
// driver. A bit-accurate model of the block ring, check-word generation and
// differential biphase coder predicts every output word, and the monitor
// compares each one against the oldest prediction. The run steps through
// phases of sender gaps and receiver stalls, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module rds_group_biphase_encoder_tb import rgbe_pkg::*;;

    localparam int          RING_DEPTH = 64;
    localparam logic [1:0]  REQ_UNUSED = 2'd3;
    localparam logic [10:0] CHECK_POLY = 11'h5B9;
    localparam int          HOLD_CYCLES = 400;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        logic        cp;
        logic        half;
    } t_enc_word;

    typedef struct packed {
        logic sel;
        logic pol;
        logic half;
    } t_biphase_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type = REQ_TICK;
    logic [15:0] i_block_a = '0;
    logic [15:0] i_block_b = '0;
    logic [15:0] i_block_c = '0;
    logic [15:0] i_block_d = '0;
    logic        i_use_c_prime = 1'b0;
    logic        i_half = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_waveform_select;
    logic        o_polarity;
    logic        o_half_out;

    t_enc_word    pending_words[$];
    t_biphase_out expected_symbols[$];

    // model state
    logic [25:0] ring_mdl [RING_DEPTH];
    int          wr_ptr;
    int          rd_ptr;
    logic [4:0]  bit_cnt;
    logic [25:0] block_sr;
    logic        diff_level;
    logic [31:0] coded_sr;

    int unsigned send_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        hold_arm = 1'b0;
    logic        hold_taken = 1'b0;
    int unsigned hold_cnt = 0;
    logic        next_half = 1'b0;

    int unsigned n_add = 0;
    int unsigned n_tick = 0;
    int unsigned n_clear = 0;
    int unsigned n_unused = 0;
    int unsigned n_reload = 0;
    int unsigned n_checked = 0;
    int unsigned n_fail = 0;

    rds_group_biphase_encoder #(
        .RING_DEPTH(RING_DEPTH)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_block_a         (i_block_a),
        .i_block_b         (i_block_b),
        .i_block_c         (i_block_c),
        .i_block_d         (i_block_d),
        .i_use_c_prime     (i_use_c_prime),
        .i_half            (i_half),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_waveform_select (o_waveform_select),
        .o_polarity        (o_polarity),
        .o_half_out        (o_half_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [25:0] rds_word(input logic [15:0] data, input t_check ofs);
        logic [25:0] rem;
        rem = {data, 10'b0};
        for (int i = 25; i >= 10; i--) begin
            if (rem[i]) begin
                rem = rem ^ (26'(CHECK_POLY) << (i - 10));
            end
        end
        return {data, rem[9:0] ^ ofs};
    endfunction

    task automatic ring_store(input logic [25:0] word);
        ring_mdl[wr_ptr] = word;
        wr_ptr = (wr_ptr == RING_DEPTH - 1) ? 0 : wr_ptr + 1;
    endtask

    task automatic model_reset();
        foreach (ring_mdl[i]) ring_mdl[i] = '0;
        wr_ptr     = 0;
        rd_ptr     = 0;
        bit_cnt    = '0;
        block_sr   = '0;
        diff_level = 1'b0;
        coded_sr   = '0;
    endtask

    // advance the model by one accepted word
    task automatic biphase_step(input t_enc_word w);
        t_biphase_out sym;
        case (w.req)
            REQ_ADD: begin
                ring_store(rds_word(w.a, OFS_A));
                ring_store(rds_word(w.b, OFS_B));
                ring_store(rds_word(w.c, w.cp ? OFS_CP : OFS_C));
                ring_store(rds_word(w.d, OFS_D));
                n_add++;
            end
            REQ_CLEAR: begin
                foreach (ring_mdl[i]) ring_mdl[i] = '0;
                n_clear++;
            end
            REQ_TICK: begin
                sym.sel  = coded_sr[31] ^ coded_sr[30];
                sym.pol  = coded_sr[30];
                sym.half = w.half;
                expected_symbols.push_back(sym);
                coded_sr = coded_sr << 1;
                if (w.half) begin
                    diff_level = diff_level ^ block_sr[25];
                    coded_sr   = coded_sr | {30'b0, diff_level, ~diff_level};
                    block_sr   = block_sr << 1;
                    bit_cnt    = bit_cnt + 5'd1;
                    if (bit_cnt >= 5'd26) begin
                        bit_cnt  = '0;
                        block_sr = ring_mdl[rd_ptr];
                        rd_ptr   = (rd_ptr == RING_DEPTH - 1) ? 0 : rd_ptr + 1;
                        n_reload++;
                    end
                end
                n_tick++;
            end
            default: begin
                n_unused++;
            end
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        t_enc_word nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                biphase_step('{i_req_type, i_block_a, i_block_b, i_block_c, i_block_d,
                               i_use_c_prime, i_half});
            end
            if (!i_valid || !o_stall) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_words.pop_front();
                    i_valid       <= 1'b1;
                    i_req_type    <= nxt.req;
                    i_block_a     <= nxt.a;
                    i_block_b     <= nxt.b;
                    i_block_c     <= nxt.c;
                    i_block_d     <= nxt.d;
                    i_use_c_prime <= nxt.cp;
                    i_half        <= nxt.half;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_arm && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cnt   <= HOLD_CYCLES;
            i_stall    <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall  <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_biphase_out exp_sym;
        if (i_rst_n && o_valid && !i_stall) begin
            n_checked++;
            if (expected_symbols.size() == 0) begin
                if (n_fail < 10) begin
                    $display("unexpected output word: sel %0b pol %0b half %0b",
                             o_waveform_select, o_polarity, o_half_out);
                end
                n_fail++;
            end else begin
                exp_sym = expected_symbols.pop_front();
                if (o_waveform_select !== exp_sym.sel || o_polarity !== exp_sym.pol ||
                    o_half_out !== exp_sym.half) begin
                    if (n_fail < 10) begin
                        $display({"mismatch at word %0d: exp sel %0b pol %0b half %0b, ",
                                  "got %0b %0b %0b"},
                                 n_checked, exp_sym.sel, exp_sym.pol, exp_sym.half,
                                 o_waveform_select, o_polarity, o_half_out);
                    end
                    n_fail++;
                end
            end
        end
    end

    task automatic push_word(input logic [1:0] req, input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c, input logic [15:0] d, input logic cp,
                             input logic half);
        pending_words.push_back('{req, a, b, c, d, cp, half});
    endtask

    // mostly tick runs with alternating halves, some groups, rare clears
    task automatic push_random();
        t_enc_word   w;
        int unsigned r;
        r      = $urandom_range(99);
        w.a    = 16'($urandom);
        w.b    = 16'($urandom);
        w.c    = 16'($urandom);
        w.d    = 16'($urandom);
        w.cp   = 1'($urandom);
        w.half = 1'($urandom);
        if (r < 10) begin
            w.req = REQ_ADD;
        end else if (r < 12) begin
            w.req = REQ_CLEAR;
        end else if (r < 14) begin
            w.req = REQ_UNUSED;
        end else begin
            w.req = REQ_TICK;
            if (r >= 24) begin
                w.half    = next_half;
                next_half = ~next_half;
            end
        end
        pending_words.push_back(w);
    endtask

    task automatic wait_drain();
        while (pending_words.size() != 0 || i_valid) @(negedge i_clk);
    endtask

    initial begin
        int unsigned snd_pct [4] = '{0, 49, 0, 29};
        int unsigned rcv_pct [4] = '{0, 0, 49, 29};
        model_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed
        push_word(REQ_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        push_word(REQ_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
        push_word(REQ_ADD,    16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        push_word(REQ_ADD,    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        push_word(REQ_ADD,    16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
        push_word(REQ_ADD,    16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b0);
        push_word(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        push_word(REQ_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
        push_word(REQ_CLEAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        push_word(REQ_ADD,    16'h8001, 16'h1234, 16'hABCD, 16'h0010, 1'b1, 1'b0);
        push_word(REQ_ADD,    16'h8001, 16'h1234, 16'hABCD, 16'h0010, 1'b0, 1'b0);
        for (int k = 0; k < 10; k++) begin
            push_word(REQ_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, k[0]);
        end
        repeat (3) push_word(REQ_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
        push_word(REQ_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        wait_drain();

        // random, one phase per idling mix
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = snd_pct[ph];
            rx_stall_pct  = rcv_pct[ph];
            repeat (300) push_random();
            wait_drain();
        end

        // long receiver hold-off with the sender pushing
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        hold_arm      = 1'b1;
        repeat (50) push_random();
        wait_drain();

        while (expected_symbols.size() != 0) @(negedge i_clk);
        repeat (RING_DEPTH + 16) @(negedge i_clk);

        $display("covered %0d group, %0d tick, %0d clear and %0d unused-code words",
                 n_add, n_tick, n_clear, n_unused);
        $display("checked %0d output words across %0d ring reloads, %0d failures",
                 n_checked, n_reload, n_fail);
        if (n_fail == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("watchdog expired, %0d words still expected", expected_symbols.size());
        $display("status: fail");
        $finish;
    end

endmodule
